[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Temporal property, written out in full by the caller.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that holds at every clock edge.
`define ASSERT_INV(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)
`define ASSERT_INV(label, cond, msg)

`endif

`endif

[hw/rtl/tbd_pkg.sv]
// ----------------------------------------------------------------------------
// tbd_pkg
// Types and constants of the tape biphase edge decoder.
// ----------------------------------------------------------------------------
package tbd_pkg;

  localparam logic [7:0]  SYNC_LENGTH_RESET = 8'd16;
  localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd5000;
  localparam int          CFG_DATA_W        = 16;

  typedef enum logic [0:0] {
    CMD_EDGE = 1'b0,
    CMD_POLL = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    KIND_DATA = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef enum logic [0:0] {
    REG_SYNC_LENGTH = 1'b0,
    REG_GAP_TIMEOUT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
  } out_item_t;

endpackage

[hw/rtl/tape_biphase_edge_decoder.sv]
// A result passes through the input register and then the result register.
// Throughput: one item per cycle unless out_stall holds a waiting result; the state
// update per edge is a single compare/average pass. An item that gives no result leaves
// the input register as soon as no result is waiting under out_stall.
// Reset (rst, synchronous, active high): sync_length = 16, gap_timeout = 5000,
// decoder state cleared, sync counter reloaded, both registers empty.
// ----------------------------------------------------------------------------
// tape_biphase_edge_decoder
// Biphase-mark tape decoder: locks onto the preamble with an adaptive period
// estimate, classifies edge intervals as short or long and assembles bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tape_biphase_edge_decoder import tbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_wr_en,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [7:0]  sync_length;
  logic [15:0] gap_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_length <= SYNC_LENGTH_RESET;
      gap_timeout <= GAP_TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SYNC_LENGTH: sync_length <= cfg_wr_data[7:0];
        REG_GAP_TIMEOUT: gap_timeout <= cfg_wr_data[15:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. The stage moves on whenever the result register can take
  // a new item; it never waits on the decode itself.
  // --------------------------------------------------------------------------
  logic     stage_valid;
  in_item_t stage_item;
  logic     advance;
  logic     in_accept;

  assign advance   = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_item <= in_item;
    end
  end

  // --------------------------------------------------------------------------
  // Decoder state
  // --------------------------------------------------------------------------
  logic [31:0] last_edge_time,  last_edge_time_next;
  logic [15:0] period_estimate, period_estimate_next;
  logic [7:0]  sync_remaining,  sync_remaining_next;
  logic        receiving,       receiving_next;
  logic        current_bit,     current_bit_next;
  logic        half_phase,      half_phase_next;
  logic [7:0]  shift_byte,      shift_byte_next;
  logic [3:0]  bits_held,       bits_held_next;
  logic [15:0] bytes_received,  bytes_received_next;

  // --------------------------------------------------------------------------
  // Interval measurement and classification
  // --------------------------------------------------------------------------
  logic [31:0] interval;      // time since last edge, mod 2^32
  logic [15:0] interval_lo;   // valid once the gap check has passed
  logic        gap;           // interval beyond gap_timeout
  logic [15:0] half;          // period / 2
  logic [16:0] p_plus_half;   // 1.5 * period
  logic [17:0] p_times3;      // 3 * period
  logic [16:0] sum_short;
  logic [16:0] sum_long;
  logic        too_short;
  logic        sync_mismatch;
  logic        lock_out_range;
  logic        is_long;

  assign interval       = stage_item.timestamp - last_edge_time;
  assign interval_lo    = interval[15:0];
  assign gap            = interval > {16'd0, gap_timeout};
  assign half           = {1'b0, period_estimate[15:1]};
  assign p_plus_half    = {1'b0, period_estimate} + {1'b0, half};
  assign p_times3       = {2'b00, period_estimate} + {1'b0, period_estimate, 1'b0};
  assign sum_short      = {1'b0, period_estimate} + {1'b0, interval_lo};
  assign sum_long       = {1'b0, period_estimate} + {2'b00, interval_lo[15:1]};
  assign too_short      = interval_lo < half;
  assign sync_mismatch  = too_short || ({1'b0, interval_lo} > p_plus_half);
  assign lock_out_range = too_short || ({2'b00, interval_lo} > p_times3);
  assign is_long        = {1'b0, interval_lo} >= p_plus_half;

  // --------------------------------------------------------------------------
  // Next state and result
  // --------------------------------------------------------------------------
  logic        res_valid;
  out_item_t   res_item;
  logic        do_shift;
  logic        bit_in;
  logic [7:0]  shifted;
  logic [3:0]  bits_inc;
  logic        emit_byte;

  assign shifted  = {shift_byte[6:0], bit_in};
  assign bits_inc = bits_held + 4'd1;

  always_comb begin
    last_edge_time_next  = last_edge_time;
    period_estimate_next = period_estimate;
    sync_remaining_next  = sync_remaining;
    receiving_next       = receiving;
    current_bit_next     = current_bit;
    half_phase_next      = half_phase;
    shift_byte_next      = shift_byte;
    bits_held_next       = bits_held;
    bytes_received_next  = bytes_received;
    res_valid            = 1'b0;
    res_item             = '0;
    do_shift             = 1'b0;
    bit_in               = current_bit;
    emit_byte            = 1'b0;

    if (stage_item.command == CMD_POLL) begin
      // end of recording: only reported while a frame is in progress
      if (receiving && gap) begin
        receiving_next       = 1'b0;
        res_valid            = 1'b1;
        res_item.result_kind = KIND_DONE;
        res_item.data_byte   = 8'd0;
        res_item.byte_count  = bytes_received;
      end
    end else begin
      last_edge_time_next = stage_item.timestamp;
      priority if (gap) begin
        // signal lost: keep the period, hunt for preamble again
        sync_remaining_next = sync_length;
        receiving_next      = 1'b0;
      end else if (sync_remaining != 8'd0) begin
        if (sync_mismatch) begin
          period_estimate_next = interval_lo;
          sync_remaining_next  = sync_length;
          receiving_next       = 1'b0;
        end else begin
          period_estimate_next = sum_short[16:1];
          sync_remaining_next  = sync_remaining - 8'd1;
        end
      end else if (lock_out_range) begin
        period_estimate_next = interval_lo;
        sync_remaining_next  = sync_length;
        receiving_next       = 1'b0;
      end else begin
        period_estimate_next = is_long ? sum_long[16:1] : sum_short[16:1];
        if (!receiving) begin
          // first long interval is the start bit
          if (is_long) begin
            current_bit_next    = 1'b1;
            receiving_next      = 1'b1;
            half_phase_next     = 1'b1;
            shift_byte_next     = 8'd1;
            bits_held_next      = 4'd1;
            bytes_received_next = 16'd0;
          end
        end else if (is_long) begin
          current_bit_next = ~current_bit;
          half_phase_next  = 1'b1;
          bit_in           = ~current_bit;
          do_shift         = 1'b1;
        end else begin
          // second short of a pair carries the bit
          half_phase_next = ~half_phase;
          do_shift        = ~half_phase;
        end
      end
    end

    if (do_shift) begin
      if (bits_inc == 4'd8) begin
        emit_byte            = 1'b1;
        res_valid            = 1'b1;
        res_item.result_kind = KIND_DATA;
        res_item.data_byte   = shifted;
        res_item.byte_count  = bytes_received;
        bytes_received_next  = bytes_received + 16'd1;
        shift_byte_next      = 8'd0;
        bits_held_next       = 4'd0;
      end else begin
        shift_byte_next = shifted;
        bits_held_next  = bits_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time  <= 32'd0;
      period_estimate <= 16'd0;
      sync_remaining  <= SYNC_LENGTH_RESET;
      receiving       <= 1'b0;
      current_bit     <= 1'b0;
      half_phase      <= 1'b0;
      shift_byte      <= 8'd0;
      bits_held       <= 4'd0;
      bytes_received  <= 16'd0;
    end else if (advance) begin
      last_edge_time  <= last_edge_time_next;
      period_estimate <= period_estimate_next;
      sync_remaining  <= sync_remaining_next;
      receiving       <= receiving_next;
      current_bit     <= current_bit_next;
      half_phase      <= half_phase_next;
      shift_byte      <= shift_byte_next;
      bits_held       <= bits_held_next;
      bytes_received  <= bytes_received_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_item <= res_item;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_INV(a_rx_locked, !receiving || (sync_remaining == 8'd0),
              "receiving while unlocked")
  `ASSERT_INV(a_bits_range, !receiving || (bits_held <= 4'd7),
              "bit count out of range")
  `ASSERT_PROP(a_byte_clear,
               (advance && emit_byte) |=> (bits_held == 4'd0 && shift_byte == 8'd0),
               "shifter not cleared after byte")
  `ASSERT_PROP(a_byte_count,
               (advance && emit_byte) |=> (bytes_received == $past(bytes_received) + 16'd1),
               "byte count not advanced")
  `ASSERT_PROP(a_done_clears,
               (advance && res_valid && res_item.result_kind == KIND_DONE) |=> !receiving,
               "receiving after end of recording")

endmodule

[tb/tb_tape_biphase_edge_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tape_biphase_edge_decoder
// Self-checking bench for the biphase tape decoder. Edge and poll items are
// queued per phase, driven with random idle gaps, and mirrored by a cycle
// free decoder model; every result item is checked against that model.
// ----------------------------------------------------------------------------
module tb_tape_biphase_edge_decoder;
  import tbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned IDLE_PCT    = 17;
  // bytes in the unbroken run of long intervals with no idling
  localparam int unsigned RUN_BYTES   = 40;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_wr_en   = 1'b0;
  cfg_reg_t              cfg_index   = REG_SYNC_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  in_item_t              in_item     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  out_item_t             out_item;

  tape_biphase_edge_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  always #2 clk = ~clk;

  // items waiting for the driver, results waiting for the monitor
  in_item_t    tape_items[$];
  out_item_t   decoded_due[$];
  logic [31:0] stamp = '0;        // timestamp of the last queued edge
  int unsigned pushed = 0;        // items queued in the current phase
  logic        idle_on = 1'b1;    // random idling on both sides
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // ---- decoder mirror: config copy and state at the block's widths ----
  logic [7:0]  sync_len_m;
  logic [15:0] gap_m;
  logic [31:0] last_edge_m;
  logic [15:0] period_m;
  logic [7:0]  sync_left_m;
  logic        rx_m;          // receiving, start bit seen
  logic        bit_m;         // current bit value
  logic        phase_m;       // half-bit phase for short pairs
  logic [7:0]  shreg_m;
  logic [3:0]  nbits_m;
  logic [15:0] nbytes_m;

  task automatic lose_lock;
    sync_left_m = sync_len_m;
    rx_m        = 1'b0;
  endtask

  task automatic shift_bit;
    out_item_t r;
    shreg_m = {shreg_m[6:0], bit_m};
    nbits_m = nbits_m + 4'd1;
    if (nbits_m == 4'd8) begin
      r.result_kind = KIND_DATA;
      r.data_byte   = shreg_m;
      r.byte_count  = nbytes_m;
      decoded_due.push_back(r);
      nbytes_m = nbytes_m + 16'd1;   // wraps at 16 bits
      shreg_m  = '0;
      nbits_m  = '0;
    end
  endtask

  // Update the mirror for one accepted item and queue any result it causes.
  task automatic decode_item(in_item_t it);
    logic [31:0] dt;
    logic [31:0] per;
    logic [31:0] hf;
    logic [31:0] avg;
    logic        is_long;
    out_item_t   r;
    dt  = it.timestamp - last_edge_m;   // modulo 2^32
    per = {16'd0, period_m};
    hf  = per >> 1;
    if (it.command == CMD_POLL) begin
      // end of recording only while receiving; last edge time stays
      if (rx_m && dt > {16'd0, gap_m}) begin
        rx_m          = 1'b0;
        r.result_kind = KIND_DONE;
        r.data_byte   = '0;
        r.byte_count  = nbytes_m;
        decoded_due.push_back(r);
      end
    end else begin
      last_edge_m = it.timestamp;
      if (dt > {16'd0, gap_m}) begin
        lose_lock();                    // signal lost, period kept
      end else if (sync_left_m != 8'd0) begin
        // preamble: interval must agree with the running estimate
        if (dt < hf || dt > per + hf) begin
          period_m = dt[15:0];
          lose_lock();
        end else begin
          avg         = (per + dt) >> 1;
          period_m    = avg[15:0];
          sync_left_m = sync_left_m - 8'd1;
        end
      end else if (dt < hf || dt > per * 3) begin
        period_m = dt[15:0];            // out of range while locked
        lose_lock();
      end else begin
        is_long  = (dt >= per + hf);
        avg      = is_long ? (per + (dt >> 1)) >> 1 : (per + dt) >> 1;
        period_m = avg[15:0];
        if (!rx_m) begin
          if (is_long) begin            // start bit
            bit_m    = 1'b1;
            rx_m     = 1'b1;
            phase_m  = 1'b1;
            shreg_m  = 8'd1;
            nbits_m  = 4'd1;
            nbytes_m = '0;
          end
        end else if (is_long) begin
          bit_m   = ~bit_m;
          phase_m = 1'b1;
          shift_bit();
        end else begin
          // every second short interval carries the bit
          phase_m = ~phase_m;
          if (phase_m) shift_bit();
        end
      end
    end
  endtask

  // ---- driver: presents queued items, mirrors each accepted one ----
  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      sync_len_m  = SYNC_LENGTH_RESET;
      gap_m       = GAP_TIMEOUT_RESET;
      last_edge_m = '0;
      period_m    = '0;
      sync_left_m = SYNC_LENGTH_RESET;
      rx_m        = 1'b0;
      bit_m       = 1'b0;
      phase_m     = 1'b0;
      shreg_m     = '0;
      nbits_m     = '0;
      nbytes_m    = '0;
    end else begin
      if (in_valid && !in_stall) decode_item(in_item);
      // a held item stays put until it is taken
      if (!in_valid || !in_stall) begin
        if (tape_items.size() != 0 &&
            !(idle_on && $urandom_range(99, 0) < IDLE_PCT)) begin
          in_item  <= tape_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor: checks each taken result against the oldest one due ----
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, got kind %0d byte %02h count %0d",
                   $time, out_item.result_kind, out_item.data_byte,
                   out_item.byte_count);
          errors++;
        end else begin
          want = decoded_due.pop_front();
          if (out_item.result_kind !== want.result_kind ||
              out_item.data_byte !== want.data_byte ||
              out_item.byte_count !== want.byte_count) begin
            $display("%0t: mismatch: expected kind %0d byte %02h count %0d,",
                     $time, want.result_kind, want.data_byte, want.byte_count,
                     " got kind %0d byte %02h count %0d",
                     out_item.result_kind, out_item.data_byte,
                     out_item.byte_count);
            errors++;
          end
        end
      end
      out_stall <= idle_on && ($urandom_range(99, 0) < IDLE_PCT);
    end
  end

  // ---- stimulus helpers ----
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);   // register takes the value at this edge
    cfg_wr_en <= 1'b0;
    if (idx == REG_SYNC_LENGTH) sync_len_m = val[7:0];
    else gap_m = val;
  endtask

  task automatic push_edge_at(logic [31:0] ts);
    in_item_t it;
    it.command   = CMD_EDGE;
    it.timestamp = ts;
    tape_items.push_back(it);
    stamp = ts;
    pushed++;
  endtask

  task automatic push_edge(int unsigned iv);
    push_edge_at(stamp + iv);
  endtask

  // poll at an offset from the last edge
  task automatic push_poll(int unsigned off);
    in_item_t it;
    it.command   = CMD_POLL;
    it.timestamp = stamp + off;
    tape_items.push_back(it);
    pushed++;
  endtask

  // interval within +-1/8 of nominal
  task automatic push_jittered(int unsigned x);
    push_edge(x - x / 8 + $urandom_range(x / 4, 0));
  endtask

  // One recording: optional dropout, preamble, start bit, random bits with
  // scattered polls and glitches, then usually a timeout poll.
  task automatic gen_burst(int unsigned gap, int unsigned slen);
    int unsigned per;
    int unsigned pmax;
    int unsigned nbits;
    logic        cur;
    logic        b;
    pmax = gap / 3;
    if (pmax > 3000) pmax = 3000;
    per = ($urandom_range(3, 0) == 0) ? $urandom_range(pmax, 8) : $urandom_range(60, 8);
    if ($urandom_range(2, 0) == 0) push_edge(gap + 1 + $urandom_range(2000, 0));
    repeat (slen + 3) push_jittered(per);
    push_jittered(2 * per);
    cur   = 1'b1;
    nbits = 7 + 8 * $urandom_range(4, 0);
    repeat (nbits) begin
      if ($urandom_range(59, 0) == 0) push_edge($urandom_range(4 * per, 0));
      if ($urandom_range(9, 0) == 0) push_poll($urandom_range(gap, 0));
      b = 1'($urandom_range(1, 0));
      if (b != cur) begin
        push_jittered(2 * per);   // long: toggles the bit
        cur = b;
      end else begin
        push_jittered(per);       // two shorts: repeats the bit
        push_jittered(per);
      end
    end
    if ($urandom_range(3, 0) != 0) push_poll(gap + 1 + $urandom_range(5000, 0));
    else push_poll($urandom());
  endtask

  // Wait for every item to be taken and every result to arrive, then cover
  // the two-stage pipeline for items that give no result.
  task automatic settle;
    @(negedge clk);
    while (tape_items.size() != 0 || in_valid || decoded_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(logic [7:0] slen, logic [15:0] gap, int unsigned n);
    write_reg(REG_SYNC_LENGTH, {8'd0, slen});
    write_reg(REG_GAP_TIMEOUT, gap);
    push_edge_at($urandom());
    pushed = 0;
    while (pushed < n) gen_burst(gap, slen);
    settle();
  endtask

  // ---- test sequence ----
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: short lock, timestamp extremes and wrap, dropout, glitch,
    // start bit, one 0xAA byte, polls on both sides of the timeout.
    write_reg(REG_SYNC_LENGTH, 16'd2);
    write_reg(REG_GAP_TIMEOUT, 16'd100);
    push_poll(0);               // idle poll, no result
    push_edge_at(32'd0);
    push_edge_at(32'hFFFF_FFFF);  // huge interval: dropout
    push_edge_at(32'd0);          // interval through the wrap
    repeat (4) push_edge(10);
    push_edge(3);               // too short while locked
    repeat (3) push_edge(10);
    push_edge(20);              // start bit
    repeat (7) push_edge(20);
    push_poll(50);
    push_poll(101);             // past the timeout: recording done
    push_edge(200);
    settle();

    run_random(8'd16, 16'd5000, 450);

    // One unbroken run of long intervals, no idling.
    idle_on = 1'b0;
    write_reg(REG_SYNC_LENGTH, 16'd4);
    write_reg(REG_GAP_TIMEOUT, 16'd200);
    push_edge(1000);
    repeat (10) push_edge(20);
    push_edge(40);
    repeat (7 + 8 * (RUN_BYTES - 1)) push_edge(40);
    push_poll(201);
    settle();
    idle_on = 1'b1;

    run_random(8'd255, 16'd65535, 600);

    // Smallest settings: tiny intervals, mostly noise.
    write_reg(REG_SYNC_LENGTH, 16'd1);
    write_reg(REG_GAP_TIMEOUT, 16'd1);
    push_edge_at($urandom());
    repeat (150) begin
      if ($urandom_range(3, 0) == 0) push_poll($urandom_range(3, 0));
      else push_edge($urandom_range(3, 0));
    end
    settle();

    run_random(8'd0, 16'd3000, 250);   // zero sync length: lock at once
    run_random(8'd1, 16'd65535, 150);

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
